// ----- rtl/core/ttce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_pkg - shared types and constants of the text terminal cursor engine
// Command layout, configuration bundle, byte codes and palette colours.
// ----------------------------------------------------------------------------
package ttce_pkg;

  // Command codes
  localparam logic [1:0] ACT_GLYPH  = 2'd0;
  localparam logic [1:0] ACT_SCROLL = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_COLUMNS    = 2'd0;
  localparam logic [1:0] REG_ROWS       = 2'd1;
  localparam logic [1:0] REG_DEFAULT_FG = 2'd2;
  localparam logic [1:0] REG_BACKGROUND = 2'd3;

  // Register reset values
  localparam logic [7:0]  COLUMNS_RESET    = 8'd80;
  localparam logic [7:0]  ROWS_RESET       = 8'd25;
  localparam logic [23:0] DEFAULT_FG_RESET = 24'hFFFFFF;

  // Control bytes
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;

  // Escape selectors
  localparam logic [7:0] ESC_RED     = 8'h72; // r
  localparam logic [7:0] ESC_GREEN   = 8'h67; // g
  localparam logic [7:0] ESC_YELLOW  = 8'h79; // y
  localparam logic [7:0] ESC_MAGENTA = 8'h6D; // m
  localparam logic [7:0] ESC_BLUE    = 8'h62; // b
  localparam logic [7:0] ESC_AQUA    = 8'h61; // a
  localparam logic [7:0] ESC_WHITE   = 8'h77; // w
  localparam logic [7:0] ESC_NORMAL  = 8'h6E; // n
  localparam logic [7:0] ESC_CLEAR   = 8'h63; // c

  // Palette
  localparam logic [23:0] COL_RED     = 24'hFF5555;
  localparam logic [23:0] COL_GREEN   = 24'h55FF55;
  localparam logic [23:0] COL_YELLOW  = 24'hFFFF55;
  localparam logic [23:0] COL_MAGENTA = 24'hFF28FF;
  localparam logic [23:0] COL_BLUE    = 24'h5555FF;
  localparam logic [23:0] COL_AQUA    = 24'h55FFFF;
  localparam logic [23:0] COL_WHITE   = 24'hFFFFFF;

  // Tab stop spacing, as a shift
  localparam int unsigned TAB_SHIFT = 3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  glyph;
    logic [7:0]  cell_column;
    logic [7:0]  cell_row;
    logic [23:0] ink_colour;
    logic        last;
  } cmd_t;

  // Up to two commands produced by one byte, in delivery order
  typedef struct packed {
    logic [1:0] count;
    cmd_t       cmd0;
    cmd_t       cmd1;
  } push_t;

  typedef struct packed {
    logic [7:0]  columns;
    logic [7:0]  rows;
    logic [23:0] default_fg;
  } cfg_t;

endpackage : ttce_pkg
`default_nettype wire

// ----- rtl/core/ttce_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_decode - per-byte cursor update and command generation
// Holds cursor, colour and escape state; turns one byte into up to two commands.
// ----------------------------------------------------------------------------
module ttce_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      char_code,
  input  wire ttce_pkg::cfg_t  cfg,
  output ttce_pkg::push_t      push
);

  logic [7:0]  col;
  logic [7:0]  row;
  logic [23:0] fg;
  logic        esc;
  logic [7:0]  col_next;
  logic [7:0]  row_next;
  logic [23:0] fg_next;
  logic        esc_next;

  logic        row_at_end;
  logic [8:0]  tab_sum;
  logic [8:0]  tab_round;
  logic [7:0]  g_col;
  logic [7:0]  g_row;
  logic        g_scroll;

  assign row_at_end = ({1'b0, row} + 9'd1) >= {1'b0, cfg.rows};
  assign tab_sum    = {1'b0, col} + 9'd8;
  assign tab_round  = (tab_sum >> ttce_pkg::TAB_SHIFT) << ttce_pkg::TAB_SHIFT;

  // Glyph placement after an optional wrap
  always_comb begin
    g_col    = col;
    g_row    = row;
    g_scroll = 1'b0;
    if (col >= cfg.columns) begin
      g_col = 8'd0;
      if (row_at_end) begin
        g_scroll = 1'b1;
      end else begin
        g_row = row + 8'd1;
      end
    end
  end

  always_comb begin
    col_next = col;
    row_next = row;
    fg_next  = fg;
    esc_next = esc;
    push     = '0;
    if (accept) begin
      if (esc) begin
        esc_next = 1'b0;
        case (char_code)
          ttce_pkg::ESC_RED:     fg_next = ttce_pkg::COL_RED;
          ttce_pkg::ESC_GREEN:   fg_next = ttce_pkg::COL_GREEN;
          ttce_pkg::ESC_YELLOW:  fg_next = ttce_pkg::COL_YELLOW;
          ttce_pkg::ESC_MAGENTA: fg_next = ttce_pkg::COL_MAGENTA;
          ttce_pkg::ESC_BLUE:    fg_next = ttce_pkg::COL_BLUE;
          ttce_pkg::ESC_AQUA:    fg_next = ttce_pkg::COL_AQUA;
          ttce_pkg::ESC_WHITE:   fg_next = ttce_pkg::COL_WHITE;
          ttce_pkg::ESC_NORMAL:  fg_next = cfg.default_fg;
          ttce_pkg::ESC_CLEAR: begin
            col_next         = 8'd0;
            row_next         = 8'd0;
            push.count       = 2'd1;
            push.cmd0.action = ttce_pkg::ACT_CLEAR;
            push.cmd0.last   = 1'b1;
          end
          default: ;
        endcase
      end else begin
        case (char_code)
          ttce_pkg::CH_LF: begin
            col_next = 8'd0;
            if (row_at_end) begin
              push.count       = 2'd1;
              push.cmd0.action = ttce_pkg::ACT_SCROLL;
              push.cmd0.last   = 1'b1;
            end else begin
              row_next = row + 8'd1;
            end
          end
          ttce_pkg::CH_TAB: col_next = tab_round[8] ? 8'hFF : tab_round[7:0];
          ttce_pkg::CH_CR:  col_next = 8'd0;
          ttce_pkg::CH_BS: begin
            if (col != 8'd0) begin
              col_next = col - 8'd1;
            end
          end
          ttce_pkg::CH_ESC: esc_next = 1'b1;
          default: begin
            row_next = g_row;
            col_next = (g_col != 8'hFF) ? g_col + 8'd1 : g_col;
            // scroll goes out first, glyph second
            push.cmd1.action      = ttce_pkg::ACT_GLYPH;
            push.cmd1.glyph       = char_code;
            push.cmd1.cell_column = g_col;
            push.cmd1.cell_row    = g_row;
            push.cmd1.ink_colour  = fg;
            push.cmd1.last        = 1'b1;
            if (g_scroll) begin
              push.count       = 2'd2;
              push.cmd0.action = ttce_pkg::ACT_SCROLL;
            end else begin
              push.count = 2'd1;
              push.cmd0  = push.cmd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= 8'd0;
      row <= 8'd0;
      fg  <= ttce_pkg::DEFAULT_FG_RESET;
      esc <= 1'b0;
    end else begin
      col <= col_next;
      row <= row_next;
      fg  <= fg_next;
      esc <= esc_next;
    end
  end

endmodule : ttce_decode
`default_nettype wire

// ----- rtl/core/ttce_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_cmd_fifo - four-entry command queue
// Takes up to two commands a cycle, hands out one; head is the output.
// ----------------------------------------------------------------------------
module ttce_cmd_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ttce_pkg::push_t push,
  input  wire logic            pop,
  output ttce_pkg::cmd_t       head,
  output logic                 not_empty,
  output logic                 room
);

  ttce_pkg::cmd_t store [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;

  assign head       = store[rd_ptr];
  assign not_empty  = (count != 3'd0);
  // keep space for a two-command byte
  assign room       = (count < 3'd3);
  assign count_next = count + {1'b0, push.count} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      store[wr_ptr] <= push.cmd0;
    end
    if (push.count == 2'd2) begin
      store[wr_ptr + 2'd1] <= push.cmd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule : ttce_cmd_fifo
`default_nettype wire

// ----- rtl/core/text_terminal_cursor_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine - character stream to draw/scroll/clear requests
// Tracks cursor, colour and escape state and queues the requests of each byte.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------------
//  char    | char_valid, char_stall | char_code[7:0]
//  cmd     | cmd_valid, cmd_stall   | action, glyph, cell_column, cell_row,
//          |                        | ink_colour, last
//  cfg     | cfg_write              | cfg_index[1:0], cfg_data[23:0]
//
//  One byte is taken every cycle while char_stall is low; its requests are
//  offered from the next cycle on, one a cycle while cmd_stall is low, out
//  of a four-entry queue. A byte that wraps at the bottom row yields two
//  requests (scroll, glyph). char_stall rises when fewer than two queue slots
//  are free, so it comes from a register and never from cmd_stall directly.
//  Reset (rst, synchronous) homes the cursor, loads the reset sizes and
//  colours and empties the queue; there is no clearing pass.
// ----------------------------------------------------------------------------
module text_terminal_cursor_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte requests
  input  wire logic        char_valid,
  output logic             char_stall,
  input  wire logic [7:0]  char_code,
  // command requests
  output logic             cmd_valid,
  input  wire logic        cmd_stall,
  output logic [1:0]       action,
  output logic [7:0]       glyph,
  output logic [7:0]       cell_column,
  output logic [7:0]       cell_row,
  output logic [23:0]      ink_colour,
  output logic             last,
  // configuration writes
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  ttce_pkg::cfg_t  cfg;
  ttce_pkg::push_t push;
  ttce_pkg::cmd_t  head;
  logic            accept;
  logic            pop;
  logic            room;

  // Configuration registers. The background colour is consumed by the
  // renderer only; no request field carries it, so drop its writes here.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns    <= ttce_pkg::COLUMNS_RESET;
      cfg.rows       <= ttce_pkg::ROWS_RESET;
      cfg.default_fg <= ttce_pkg::DEFAULT_FG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ttce_pkg::REG_COLUMNS:    cfg.columns    <= cfg_data[7:0];
        ttce_pkg::REG_ROWS:       cfg.rows       <= cfg_data[7:0];
        ttce_pkg::REG_DEFAULT_FG: cfg.default_fg <= cfg_data;
        ttce_pkg::REG_BACKGROUND: ;
        default: ;
      endcase
    end
  end

  // Hold the byte side while the queue cannot absorb a two-request byte
  assign char_stall = !room;
  assign accept     = char_valid && room;
  assign pop        = cmd_valid && !cmd_stall;

  ttce_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .cfg       (cfg),
    .push      (push)
  );

  ttce_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (cmd_valid),
    .room      (room)
  );

  // Present the queue head
  assign action      = head.action;
  assign glyph       = head.glyph;
  assign cell_column = head.cell_column;
  assign cell_row    = head.cell_row;
  assign ink_colour  = head.ink_colour;
  assign last        = head.last;

  // The byte side can only be held back while requests are queued
  a_stall_needs_backlog : assert property (@(posedge clk) disable iff (rst)
    char_stall |-> cmd_valid)
    else $error("byte side stalled with an empty request queue");

  // Nothing is offered in the cycle after reset
  a_empty_after_reset : assert property (@(posedge clk)
    rst |=> !cmd_valid)
    else $error("request offered straight after reset");

  // A clear is always the only request of its byte
  a_clear_is_last : assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && action == ttce_pkg::ACT_CLEAR) |-> last)
    else $error("clear request not marked last");

  // A glyph always closes its byte's requests
  a_glyph_is_last : assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && action == ttce_pkg::ACT_GLYPH) |-> last)
    else $error("glyph request not marked last");

endmodule : text_terminal_cursor_engine
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the text terminal cursor engine
// Streams character bytes through the valid/stall byte channel, mirrors the
// cursor, colour and escape state in a local predictor, and matches every
// draw, scroll and clear request in order against the predicted list.
// Configuration is rewritten between phases, only once the engine is idle.
// ----------------------------------------------------------------------------
module tb;
  import ttce_pkg::*;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // Byte channel: driven on the falling edge
  logic       char_valid = 1'b0;
  logic       char_stall;
  logic [7:0] char_code  = 8'h00;

  // Command channel
  logic        cmd_valid;
  logic        cmd_stall = 1'b0;
  logic [1:0]  action;
  logic [7:0]  glyph;
  logic [7:0]  cell_column;
  logic [7:0]  cell_row;
  logic [23:0] ink_colour;
  logic        last;

  // Configuration port
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_COLUMNS;
  logic [23:0] cfg_data  = 24'h000000;

  text_terminal_cursor_engine dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .action      (action),
    .glyph       (glyph),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .ink_colour  (ink_colour),
    .last        (last),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Terminal mirror: registers as the engine holds them after reset
  logic [7:0]  term_columns = COLUMNS_RESET;
  logic [7:0]  term_rows    = ROWS_RESET;
  logic [23:0] term_deflt   = DEFAULT_FG_RESET;
  logic [23:0] term_backgr  = 24'h000000;

  // Cursor, ink and escape flag of the mirror
  logic [7:0]  cur_col  = 8'd0;
  logic [7:0]  cur_row  = 8'd0;
  logic [23:0] cur_ink  = DEFAULT_FG_RESET;
  logic        esc_open = 1'b0;

  // Requests predicted but not yet seen on the command channel, oldest first
  cmd_t awaited_cmds[$];

  // Idling switch shared by both sides; cleared for the final stretch
  bit idle_on = 1'b1;
  int stall_left = 0;
  int err_count = 0;

  // Escape selectors that change state; random escapes mostly pick one
  logic [7:0] selectors[9] = '{ESC_RED, ESC_GREEN, ESC_YELLOW, ESC_MAGENTA,
                               ESC_BLUE, ESC_AQUA, ESC_WHITE, ESC_NORMAL,
                               ESC_CLEAR};

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic cmd_t make_cmd(input logic [1:0] act, input logic [7:0] g,
                                    input logic [7:0] c, input logic [7:0] r,
                                    input logic [23:0] ink);
    cmd_t k;
    k.action      = act;
    k.glyph       = g;
    k.cell_column = c;
    k.cell_row    = r;
    k.ink_colour  = ink;
    k.last        = 1'b0;
    return k;
  endfunction

  // Move to column 0 of the next row; report a scroll when already at the
  // bottom. Compare in full integers so a row count of zero always scrolls.
  function automatic bit step_row();
    bit scroll;
    scroll = (int'(cur_row) + 1 >= int'(term_rows));
    if (!scroll) cur_row = cur_row + 8'd1;
    cur_col = 8'd0;
    return scroll;
  endfunction

  // Work out the requests one accepted byte causes and queue them
  task automatic predict_byte(input logic [7:0] c);
    cmd_t cmds[$];
    int   tab_to;
    if (esc_open) begin
      esc_open = 1'b0;
      case (c)
        ESC_RED:     cur_ink = COL_RED;
        ESC_GREEN:   cur_ink = COL_GREEN;
        ESC_YELLOW:  cur_ink = COL_YELLOW;
        ESC_MAGENTA: cur_ink = COL_MAGENTA;
        ESC_BLUE:    cur_ink = COL_BLUE;
        ESC_AQUA:    cur_ink = COL_AQUA;
        ESC_WHITE:   cur_ink = COL_WHITE;
        ESC_NORMAL:  cur_ink = term_deflt;
        ESC_CLEAR: begin
          cur_col = 8'd0;
          cur_row = 8'd0;
          cmds.push_back(make_cmd(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 24'd0));
        end
        default: ; // unknown selector, a second ESC included: drop it
      endcase
    end else begin
      case (c)
        CH_LF: begin
          if (step_row()) cmds.push_back(make_cmd(ACT_SCROLL, 8'd0, 8'd0, 8'd0, 24'd0));
        end
        CH_TAB: begin
          // round col+1 up to the next tab stop, saturate at column 255
          tab_to = ((int'(cur_col) + 8) >> TAB_SHIFT) << TAB_SHIFT;
          cur_col = (tab_to > 255) ? 8'd255 : tab_to[7:0];
        end
        CH_CR:  cur_col = 8'd0;
        CH_BS:  if (cur_col != 8'd0) cur_col = cur_col - 8'd1;
        CH_ESC: esc_open = 1'b1;
        default: begin
          // wrap before drawing once the column has reached the width
          if (cur_col >= term_columns) begin
            if (step_row()) cmds.push_back(make_cmd(ACT_SCROLL, 8'd0, 8'd0, 8'd0, 24'd0));
          end
          cmds.push_back(make_cmd(ACT_GLYPH, c, cur_col, cur_row, cur_ink));
          if (cur_col != 8'd255) cur_col = cur_col + 8'd1;
        end
      endcase
    end
    if (cmds.size() > 0) cmds[cmds.size() - 1].last = 1'b1;
    foreach (cmds[i]) awaited_cmds.push_back(cmds[i]);
  endtask

  // --------------------------------------------------------------------------
  // Command checker: every accepted request against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cmd_t want;
    if (!rst && cmd_valid === 1'b1 && !cmd_stall) begin
      if (awaited_cmds.size() == 0) begin
        err_count++;
        $display("%0t: unexpected request: expected none, actual action %h glyph %h",
                 $time, action, glyph);
      end else begin
        want = awaited_cmds.pop_front();
        check_field("action", want.action, action);
        check_field("glyph", want.glyph, glyph);
        check_field("cell_column", want.cell_column, cell_column);
        check_field("cell_row", want.cell_row, cell_row);
        check_field("ink_colour", want.ink_colour, ink_colour);
        check_field("last", want.last, last);
      end
    end
  end

  // Receiver: stall in random bursts while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      cmd_stall = 1'b1;
      stall_left--;
    end else begin
      cmd_stall = 1'b0;
      if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 11);
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  // Offer one byte, hold it through stalls, predict on acceptance.
  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      char_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    char_valid = 1'b1;
    char_code  = c;
    do @(posedge clk); while (char_stall);
    predict_byte(c);
    @(negedge clk);
    char_valid = 1'b0;
  endtask

  // Wait for every predicted request, then let the last bytes settle
  task automatic wait_idle();
    while (awaited_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register while the engine is idle and mirror it
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    wait_idle();
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    case (idx)
      REG_COLUMNS:    term_columns = val[7:0];
      REG_ROWS:       term_rows    = val[7:0];
      REG_DEFAULT_FG: term_deflt   = val;
      REG_BACKGROUND: term_backgr  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Lowest and highest byte are both ordinary glyphs
  task automatic test_glyph_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Tab, backspace, carriage return, backspace at column 0, line feed
  task automatic test_cursor_controls();
    send_byte(CH_TAB);
    send_byte(CH_BS);
    send_byte(CH_CR);
    send_byte(CH_BS);
    send_byte(CH_LF);
  endtask

  // Colour pick, doubled ESC, unknown selector, clear and home
  task automatic test_escapes();
    send_byte(CH_ESC);
    send_byte(ESC_RED);
    send_byte("x");
    send_byte(CH_ESC);
    send_byte(CH_ESC);
    send_byte("x");
    send_byte(CH_ESC);
    send_byte(ESC_CLEAR);
  endtask

  // One-cell screen: every glyph after the first wraps and scrolls
  task automatic test_tiny_screen();
    write_reg(REG_COLUMNS, 24'h000001);
    write_reg(REG_ROWS, 24'h000001);
    send_byte("p");
    send_byte("q");
  endtask

  // Zero sizes: every glyph wraps, every row advance scrolls
  task automatic test_zero_size();
    write_reg(REG_COLUMNS, 24'h000000);
    write_reg(REG_ROWS, 24'h000000);
    send_byte("z");
    send_byte(CH_LF);
  endtask

  // New default colour leaves the current ink alone until ESC n
  task automatic test_default_colour();
    write_reg(REG_COLUMNS, 24'h0000FF);
    write_reg(REG_ROWS, 24'h0000FF);
    write_reg(REG_DEFAULT_FG, 24'h123456);
    write_reg(REG_BACKGROUND, 24'hFFFFFF);
    send_byte("d");
    send_byte(CH_ESC);
    send_byte(ESC_NORMAL);
    send_byte("e");
  endtask

  // Cursor left beyond a width that shrinks under it
  task automatic test_shrink();
    send_byte(CH_TAB);
    send_byte(CH_TAB);
    write_reg(REG_COLUMNS, 24'h000005);
    send_byte("s");
  endtask

  // One random burst; mostly well-formed runs, some noise
  task automatic send_random_burst(output int n);
    int len;
    n = 0;
    case ($urandom_range(0, 9))
      0, 1: begin
        send_byte(8'($urandom_range(0, 255)));
        n = 1;
      end
      2, 3, 4: begin
        len = $urandom_range(1, 20);
        repeat (len) send_byte(8'($urandom_range(32, 126)));
        n = len;
      end
      5: begin
        send_byte(CH_LF);
        n = 1;
      end
      6, 7: begin
        // escape with a known selector most of the time, any byte otherwise
        send_byte(CH_ESC);
        if ($urandom_range(0, 4) != 0) send_byte(selectors[$urandom_range(0, 8)]);
        else send_byte(8'($urandom_range(0, 255)));
        n = 2;
      end
      8: begin
        // long tab runs reach the saturated column 255
        len = $urandom_range(1, 35);
        repeat (len) send_byte(CH_TAB);
        n = len;
      end
      default: begin
        send_byte(($urandom_range(0, 1) != 0) ? CH_BS : CH_CR);
        n = 1;
      end
    endcase
  endtask

  // Random byte stream over several screen settings, extremes among them
  task automatic test_random_stream();
    logic [7:0] cols;
    logic [7:0] rows;
    int sent;
    int got;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cols = COLUMNS_RESET; rows = ROWS_RESET; end
        1: begin cols = 8'd1; rows = 8'd255; end
        2: begin cols = 8'd255; rows = 8'd1; end
        default: begin
          cols = 8'($urandom_range(1, 40));
          rows = 8'($urandom_range(1, 10));
        end
      endcase
      // upper data bits are random; only the low byte is a size
      write_reg(REG_COLUMNS, {16'($urandom_range(0, 65535)), cols});
      write_reg(REG_ROWS, {16'($urandom_range(0, 65535)), rows});
      write_reg(REG_DEFAULT_FG, 24'($urandom_range(0, 24'hFFFFFF)));
      write_reg(REG_BACKGROUND, 24'($urandom_range(0, 24'hFFFFFF)));
      if (ph == 5) idle_on = 1'b0; // final stretch runs flat out
      sent = 0;
      while (sent < 100) begin
        send_random_burst(got);
        sent += got;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int guard;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_glyph_extremes();
    test_cursor_controls();
    test_escapes();
    test_tiny_screen();
    test_zero_size();
    test_default_colour();
    test_shrink();
    test_random_stream();

    // drain with a bound, then let the engine settle
    guard = 0;
    while (awaited_cmds.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
    if (awaited_cmds.size() != 0) begin
      err_count++;
      $display("%0t: requests missing: expected %0d more, actual 0",
               $time, awaited_cmds.size());
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
